// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL files of the policer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Consequent must hold at the same edge as the antecedent.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rstn, cond, msg)
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== rtl/core/prp_pkg.sv =====
// Shared types and constants of the packet rate policer.
`timescale 1ns / 1ps

package prp_pkg;

    // Microseconds in one second.
    localparam logic [31:0] USEC_PER_SEC = 32'd1000000;

    // Parameter defaults.
    localparam int SCALE_SHIFT_DEFAULT = 8;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_TX_ENABLE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RX_ENABLE = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TX_RATE   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RX_RATE   = 8'd3;

    // One classified packet, handed from the front to the back.
    typedef struct packed {
        logic        dir;
        logic        active;
        logic        en;
        logic [31:0] reqd;
        logic [31:0] now_sec;
        logic [19:0] now_usec;
    } prp_work_t;

    // One decision, held in the result queue.
    typedef struct packed {
        logic        drop;
        logic [31:0] drops_seen;
    } prp_result_t;

endpackage

// ===== rtl/core/prp_fifo.sv =====
// Small first-in first-out queue with show-ahead read data.
`timescale 1ns / 1ps

module prp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/core/prp_front.sv =====
// Front end: configuration registers, packet intake and required-time product.
`timescale 1ns / 1ps

module prp_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [prp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [31:0]                      cfg_data,
    input  logic                             push,
    output logic                             full,
    input  logic                             direction,
    input  logic [15:0]                      length,
    input  logic [31:0]                      now_sec,
    input  logic [19:0]                      now_usec,
    input  logic                             queue_full,
    output logic                             work_wr,
    output prp_pkg::prp_work_t               work
);
    import prp_pkg::*;

    logic        tx_enable_reg;
    logic        tx_enable_next;
    logic        rx_enable_reg;
    logic        rx_enable_next;
    logic [31:0] tx_rate_reg;
    logic [31:0] tx_rate_next;
    logic [31:0] rx_rate_reg;
    logic [31:0] rx_rate_next;
    logic [31:0] rate_sel;
    logic [47:0] product;

    assign cfg_ready = 1'b1;

    // Register writes; unknown indexes are ignored.
    always_comb
    begin
        tx_enable_next = tx_enable_reg;
        rx_enable_next = rx_enable_reg;
        tx_rate_next   = tx_rate_reg;
        rx_rate_next   = rx_rate_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_TX_ENABLE: tx_enable_next = cfg_data[0];
                REG_RX_ENABLE: rx_enable_next = cfg_data[0];
                REG_TX_RATE:   tx_rate_next   = cfg_data;
                REG_RX_RATE:   rx_rate_next   = cfg_data;
                default:       tx_enable_next = tx_enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_enable_reg <= 1'b0;
            rx_enable_reg <= 1'b0;
            tx_rate_reg   <= '0;
            rx_rate_reg   <= '0;
        end
        else
        begin
            tx_enable_reg <= tx_enable_next;
            rx_enable_reg <= rx_enable_next;
            tx_rate_reg   <= tx_rate_next;
            rx_rate_reg   <= rx_rate_next;
        end
    end

    // Required time is rate times length, kept to 32 bits; the queue registers it.
    assign rate_sel = direction ? tx_rate_reg : rx_rate_reg;
    assign product  = rate_sel * length;

    // Classify the item and hand it to the work queue.
    assign full    = queue_full;
    assign work_wr = push && !queue_full;

    always_comb
    begin
        work.dir      = direction;
        work.active   = (length != 16'd0);
        work.en       = direction ? tx_enable_reg : rx_enable_reg;
        work.reqd     = product[31:0];
        work.now_sec  = now_sec;
        work.now_usec = now_usec;
    end

endmodule

// ===== rtl/core/prp_back.sv =====
// Back end: per-direction last-send times, drop decision and drop count.
`timescale 1ns / 1ps

module prp_back #(
    parameter int SCALE_SHIFT = prp_pkg::SCALE_SHIFT_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  prp_pkg::prp_work_t   work,
    input  logic                 work_valid,
    output logic                 work_take,
    input  logic                 res_full,
    output logic                 res_wr,
    output prp_pkg::prp_result_t res
);
    import prp_pkg::*;

    logic [31:0] tx_last_sec_reg;
    logic [31:0] tx_last_sec_next;
    logic [31:0] tx_last_usec_reg;
    logic [31:0] tx_last_usec_next;
    logic [31:0] rx_last_sec_reg;
    logic [31:0] rx_last_sec_next;
    logic [31:0] rx_last_usec_reg;
    logic [31:0] rx_last_usec_next;
    logic [31:0] drop_total_reg;
    logic [31:0] drop_total_next;

    logic [31:0] ls;
    logic [31:0] lu;
    logic [31:0] nusec;
    logic [31:0] sec_diff;
    logic [31:0] gap;
    logic [31:0] elapsed;
    logic [31:0] req_us;
    logic [31:0] lu_adv;
    logic        warm;
    logic        in_window;
    logic        upd;
    logic        drop_hit;
    logic [31:0] new_sec;
    logic [31:0] new_usec;

    // One item per cycle while there is room for its result.
    assign work_take = work_valid && !res_full;
    assign res_wr    = work_take;

    // Window test, elapsed time and advanced last time.
    always_comb
    begin
        ls        = work.dir ? tx_last_sec_reg : rx_last_sec_reg;
        lu        = work.dir ? tx_last_usec_reg : rx_last_usec_reg;
        nusec     = {12'd0, work.now_usec};
        warm      = (tx_last_sec_reg == '0) || (rx_last_sec_reg == '0);
        sec_diff  = work.now_sec - ls;
        in_window = (ls == work.now_sec) || ((sec_diff == 32'd1) && (nusec < lu));
        gap       = (nusec < lu) ? nusec + (USEC_PER_SEC - lu) : nusec - lu;
        elapsed   = gap << SCALE_SHIFT;
        req_us    = work.reqd >> SCALE_SHIFT;
        lu_adv    = lu + req_us;
    end

    // Decision and new last-send time.
    always_comb
    begin
        upd      = 1'b0;
        drop_hit = 1'b0;
        new_sec  = ls;
        new_usec = lu;
        if (work.active)
        begin
            if (warm)
            begin
                upd      = 1'b1;
                new_sec  = work.now_sec;
                new_usec = nusec;
            end
            else if (work.en)
            begin
                if (in_window)
                begin
                    if (elapsed < work.reqd)
                    begin
                        drop_hit = 1'b1;
                    end
                    else
                    begin
                        upd = 1'b1;
                        if (lu_adv > USEC_PER_SEC)
                        begin
                            new_usec = lu_adv - USEC_PER_SEC;
                            new_sec  = work.now_sec;
                        end
                        else
                        begin
                            new_usec = lu_adv;
                        end
                    end
                end
                else
                begin
                    // Gap too old or time went backwards: re-base.
                    upd      = 1'b1;
                    new_sec  = work.now_sec - 32'd1;
                    new_usec = nusec + req_us;
                end
            end
        end
    end

    // State update for the item taken this cycle.
    always_comb
    begin
        tx_last_sec_next  = tx_last_sec_reg;
        tx_last_usec_next = tx_last_usec_reg;
        rx_last_sec_next  = rx_last_sec_reg;
        rx_last_usec_next = rx_last_usec_reg;
        drop_total_next   = drop_total_reg;
        if (work_take && upd)
        begin
            if (work.dir)
            begin
                tx_last_sec_next  = new_sec;
                tx_last_usec_next = new_usec;
            end
            else
            begin
                rx_last_sec_next  = new_sec;
                rx_last_usec_next = new_usec;
            end
        end
        if (work_take && drop_hit)
        begin
            drop_total_next = drop_total_reg + 32'd1;
        end
    end

    always_comb
    begin
        res.drop       = drop_hit;
        res.drops_seen = drop_total_reg + {31'd0, drop_hit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_last_sec_reg  <= '0;
            tx_last_usec_reg <= '0;
            rx_last_sec_reg  <= '0;
            rx_last_usec_reg <= '0;
            drop_total_reg   <= '0;
        end
        else
        begin
            tx_last_sec_reg  <= tx_last_sec_next;
            tx_last_usec_reg <= tx_last_usec_next;
            rx_last_sec_reg  <= rx_last_sec_next;
            rx_last_usec_reg <= rx_last_usec_next;
            drop_total_reg   <= drop_total_next;
        end
    end

endmodule

// ===== rtl/core/packet_rate_policer_core.sv =====
// An accepted item is stored in the work queue, then decided by the back end and written to the result queue.
// Throughput: one item per cycle while the result queue has room, set by the state update in the back end.
// The work queue and result queue each hold QUEUE_DEPTH items, so both sides stall alone.
// Reset clears configuration, last-send times, the drop count and both queues.
// No clearing pass is needed; the block takes items from the first edge after reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module packet_rate_policer_core #(
    parameter int SCALE_SHIFT = prp_pkg::SCALE_SHIFT_DEFAULT,
    parameter int QUEUE_DEPTH = prp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [prp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic                            direction,
    input  logic [15:0]                     length,
    input  logic [31:0]                     now_sec,
    input  logic [19:0]                     now_usec,
    output logic                            empty,
    input  logic                            pop,
    output logic                            drop,
    output logic [31:0]                     drops_seen
);
    import prp_pkg::*;

    prp_work_t   work_in;
    prp_work_t   work_out;
    logic        work_wr;
    logic        work_full;
    logic        work_empty;
    logic        work_take;
    prp_result_t res_in;
    prp_result_t res_out;
    logic        res_wr;
    logic        res_full;

    // Front end: configuration and item intake.
    prp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .direction  (direction),
        .length     (length),
        .now_sec    (now_sec),
        .now_usec   (now_usec),
        .queue_full (work_full),
        .work_wr    (work_wr),
        .work       (work_in)
    );

    // Queue between the front end and the back end.
    prp_fifo #(
        .WIDTH ($bits(prp_work_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_work_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (work_wr),
        .wr_data (work_in),
        .full    (work_full),
        .rd_en   (work_take),
        .rd_data (work_out),
        .empty   (work_empty)
    );

    // Back end: decision and state update.
    prp_back #(
        .SCALE_SHIFT (SCALE_SHIFT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work       (work_out),
        .work_valid (!work_empty),
        .work_take  (work_take),
        .res_full   (res_full),
        .res_wr     (res_wr),
        .res        (res_in)
    );

    // Result queue toward the consumer.
    prp_fifo #(
        .WIDTH ($bits(prp_result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_wr),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign drop       = res_out.drop;
    assign drops_seen = res_out.drops_seen;

    // Every item taken from the work queue yields exactly one result.
    `ASSERT_ALWAYS(a_take_matches_result, clk, rst_n, work_take == res_wr, "take and result differ")
    // The back end never writes into a full result queue.
    `ASSERT_IMPLIES(a_no_result_overflow, clk, rst_n, res_wr, !res_full, "result queue overflow")
    // Consecutive results advance the drop count by exactly their drop flag.
    `ASSERT_IMPLIES(a_drop_count_step, clk, rst_n, res_wr && $past(res_wr), res_in.drops_seen == $past(res_in.drops_seen) + {31'd0, res_in.drop}, "drop count skipped")

endmodule

// ===== bench/tb_packet_rate_policer_core.sv =====
// Self-checking testbench for the packet rate policer core.
`timescale 1ns / 1ps

module tb_packet_rate_policer_core;

    import prp_pkg::*;

    localparam int POLICE_SHIFT = SCALE_SHIFT_DEFAULT;
    localparam int HOLD_CYCLES = 64;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 160;
    localparam int REPORT_CAP = 100;

    localparam logic DIR_TX = 1'b1;
    localparam logic DIR_RX = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 8'hFF;
    localparam bit CHECKED = 1'b1;
    localparam bit PREDICTED = 1'b0;

    typedef enum {ROW_PACKET, ROW_CONFIG} row_kind_t;

    typedef struct {
        row_kind_t               kind;
        logic [CFG_INDEX_W-1:0]  idx;
        logic [31:0]             data;
        logic                    dir;
        logic [15:0]             len;
        logic [31:0]             sec;
        logic [19:0]             usec;
        bit                      typed;
        prp_result_t             want;
    } plan_row_t;

    // Block ports.
    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0]            cfg_data = '0;
    logic                   push = 1'b0;
    logic                   full;
    logic                   direction = 1'b0;
    logic [15:0]            length = '0;
    logic [31:0]            now_sec = '0;
    logic [19:0]            now_usec = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic                   drop;
    logic [31:0]            drops_seen;

    // Hand-typed expectation that travels with the item on the input side.
    logic                   note_typed = 1'b0;
    prp_result_t            note_want = '0;

    // Policer model state and configuration.
    logic        tx_on = 1'b0;
    logic        rx_on = 1'b0;
    logic [31:0] tx_rate_cfg = '0;
    logic [31:0] rx_rate_cfg = '0;
    logic [31:0] tx_mark_sec = '0;
    logic [31:0] tx_mark_usec = '0;
    logic [31:0] rx_mark_sec = '0;
    logic [31:0] rx_mark_usec = '0;
    logic [31:0] drop_tally = '0;

    prp_result_t decision_q[$];
    int          mismatches = 0;
    bit          no_idle = 1'b0;
    bit          pop_hold_request = 1'b0;

    packet_rate_policer_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .direction  (direction),
        .length     (length),
        .now_sec    (now_sec),
        .now_usec   (now_usec),
        .empty      (empty),
        .pop        (pop),
        .drop       (drop),
        .drops_seen (drops_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    // Decide one packet against the per-direction virtual clock and update the state.
    function automatic prp_result_t police_packet(input logic dir, input logic [15:0] len,
                                                  input logic [31:0] sec,
                                                  input logic [19:0] usec);
        logic [31:0] mark_s;
        logic [31:0] mark_u;
        logic [31:0] rate;
        logic [31:0] reqd;
        logic [31:0] advance;
        logic [31:0] gap;
        logic [31:0] elapsed;
        logic [31:0] nu;
        logic        on;
        prp_result_t res;

        mark_s = dir ? tx_mark_sec : rx_mark_sec;
        mark_u = dir ? tx_mark_usec : rx_mark_usec;
        rate = dir ? tx_rate_cfg : rx_rate_cfg;
        on = dir ? tx_on : rx_on;
        nu = {12'd0, usec};
        res.drop = 1'b0;

        if (len != 16'd0)
        begin
            if (rx_mark_sec == 32'd0 || tx_mark_sec == 32'd0)
            begin
                // Warm-up: only load this direction's last-send time.
                mark_s = sec;
                mark_u = nu;
            end
            else if (on)
            begin
                reqd = rate * {16'd0, len};
                advance = reqd >> POLICE_SHIFT;
                if (mark_s == sec || ((sec - mark_s) == 32'd1 && nu < mark_u))
                begin
                    if (nu < mark_u)
                        gap = nu + (USEC_PER_SEC - mark_u);
                    else
                        gap = nu - mark_u;
                    elapsed = gap << POLICE_SHIFT;
                    if (elapsed < reqd)
                    begin
                        res.drop = 1'b1;
                        drop_tally = drop_tally + 32'd1;
                    end
                    else
                    begin
                        mark_u = mark_u + advance;
                        if (mark_u > USEC_PER_SEC)
                        begin
                            mark_u = mark_u - USEC_PER_SEC;
                            mark_s = sec;
                        end
                    end
                end
                else
                begin
                    // Old gap or time going backwards: re-base the last-send time.
                    mark_s = sec - 32'd1;
                    mark_u = nu + advance;
                end
            end
        end

        if (dir)
        begin
            tx_mark_sec = mark_s;
            tx_mark_usec = mark_u;
        end
        else
        begin
            rx_mark_sec = mark_s;
            rx_mark_usec = mark_u;
        end
        res.drops_seen = drop_tally;
        return res;
    endfunction

    // Check results first, then record accepted items and register writes.
    always @(posedge clk)
    begin
        prp_result_t want;
        prp_result_t model;

        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (decision_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $display("%0t: unexpected item: drop=%0b drops_seen=%0d",
                                 $time, drop, drops_seen);
                end
                else
                begin
                    want = decision_q.pop_front();
                    if (drop !== want.drop || drops_seen !== want.drops_seen)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_CAP)
                            $display("%0t: expected drop=%0b drops_seen=%0d, got drop=%0b drops_seen=%0d",
                                     $time, want.drop, want.drops_seen, drop, drops_seen);
                    end
                end
            end

            if (push && !full)
            begin
                model = police_packet(direction, length, now_sec, now_usec);
                decision_q.push_back(note_typed ? note_want : model);
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TX_ENABLE: tx_on = cfg_data[0];
                    REG_RX_ENABLE: rx_on = cfg_data[0];
                    REG_TX_RATE:   tx_rate_cfg = cfg_data;
                    REG_RX_RATE:   rx_rate_cfg = cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    // Result side: random stalls per item, with an occasional long hold-off.
    initial
    begin : result_side
        int stall;

        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (pop_hold_request)
            begin
                pop_hold_request = 1'b0;
                stall = HOLD_CYCLES;
            end
            else
            begin
                stall = no_idle ? 0 : $urandom_range(0, 3);
            end
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    function automatic plan_row_t packet_row(input logic dir, input logic [15:0] len,
                                             input logic [31:0] sec, input logic [19:0] usec,
                                             input bit typed, input logic want_drop,
                                             input logic [31:0] want_count);
        plan_row_t r;

        r.kind = ROW_PACKET;
        r.idx = '0;
        r.data = '0;
        r.dir = dir;
        r.len = len;
        r.sec = sec;
        r.usec = usec;
        r.typed = typed;
        r.want.drop = want_drop;
        r.want.drops_seen = want_count;
        return r;
    endfunction

    function automatic plan_row_t reg_row(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [31:0] data);
        plan_row_t r;

        r = packet_row(DIR_RX, 16'd0, 32'd0, 20'd0, PREDICTED, 1'b0, 32'd0);
        r.kind = ROW_CONFIG;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    // Offer one item after a random gap and hold it until the block takes it.
    task automatic send_item(input plan_row_t r);
        int gap;

        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        direction <= r.dir;
        length <= r.len;
        now_sec <= r.sec;
        now_usec <= r.usec;
        note_typed <= r.typed;
        note_want <= r.want;
        do @(posedge clk); while (full);
    endtask

    // Stop offering items and wait until every decision has come out.
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (decision_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        plan_row_t   plan[$];
        plan_row_t   r;
        logic [31:0] clk_sec;
        int unsigned clk_usec;
        int unsigned usec_sum;
        int unsigned roll;
        int          guard;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero length, warm-up of each direction, a disabled direction.
        plan.push_back(packet_row(DIR_RX, 16'd0, 32'd5, 20'd0, CHECKED, 1'b0, 32'd0));
        plan.push_back(packet_row(DIR_TX, 16'd1, 32'd10, 20'd100, CHECKED, 1'b0, 32'd0));
        plan.push_back(packet_row(DIR_TX, 16'hFFFF, 32'd11, 20'd0, CHECKED, 1'b0, 32'd0));
        plan.push_back(packet_row(DIR_RX, 16'd1, 32'd20, 20'd999999, CHECKED, 1'b0, 32'd0));
        plan.push_back(packet_row(DIR_TX, 16'd100, 32'd12, 20'd5, CHECKED, 1'b0, 32'd0));
        plan.push_back(reg_row(REG_TX_ENABLE, 32'd1));
        plan.push_back(reg_row(REG_TX_RATE, 32'd256));
        plan.push_back(reg_row(REG_RX_ENABLE, 32'd1));
        plan.push_back(reg_row(REG_RX_RATE, 32'hFFFF_FFFF));
        // Too early, then in time, then the next second, an old gap and time going back.
        plan.push_back(packet_row(DIR_TX, 16'd10, 32'd11, 20'd5, PREDICTED, 1'b0, 32'd0));
        plan.push_back(packet_row(DIR_TX, 16'd10, 32'd11, 20'd20, PREDICTED, 1'b0, 32'd0));
        plan.push_back(packet_row(DIR_TX, 16'd10, 32'd12, 20'd5, PREDICTED, 1'b0, 32'd0));
        plan.push_back(packet_row(DIR_TX, 16'd1, 32'd14, 20'd7, PREDICTED, 1'b0, 32'd0));
        plan.push_back(packet_row(DIR_TX, 16'd1, 32'd3, 20'd0, PREDICTED, 1'b0, 32'd0));
        // Largest rate times largest length, same and next second.
        plan.push_back(packet_row(DIR_RX, 16'hFFFF, 32'd20, 20'd999999, PREDICTED, 1'b0, 32'd0));
        plan.push_back(packet_row(DIR_RX, 16'd1, 32'd21, 20'd0, PREDICTED, 1'b0, 32'd0));
        plan.push_back(packet_row(DIR_RX, 16'd0, 32'd21, 20'd0, PREDICTED, 1'b0, 32'd0));
        // A credit of 999999 microseconds lands the last time on exactly one million, then wraps.
        plan.push_back(reg_row(REG_TX_RATE, 32'd255999744));
        plan.push_back(packet_row(DIR_TX, 16'd1, 32'd3, 20'd0, PREDICTED, 1'b0, 32'd0));
        plan.push_back(packet_row(DIR_TX, 16'd1, 32'd3, 20'd5, PREDICTED, 1'b0, 32'd0));
        plan.push_back(packet_row(DIR_TX, 16'd1, 32'd3, 20'd999999, PREDICTED, 1'b0, 32'd0));
        plan.push_back(packet_row(DIR_TX, 16'd1, 32'd3, 20'hFFFFF, PREDICTED, 1'b0, 32'd0));
        plan.push_back(reg_row(REG_RX_ENABLE, 32'd0));
        plan.push_back(packet_row(DIR_RX, 16'hFFFF, 32'd21, 20'd0, PREDICTED, 1'b0, 32'd0));
        plan.push_back(reg_row(REG_TX_ENABLE, 32'd0));
        plan.push_back(reg_row(REG_RX_RATE, 32'd0));
        plan.push_back(reg_row(REG_UNMAPPED, 32'hFFFF_FFFF));
        plan.push_back(reg_row(REG_RX_ENABLE, 32'd1));
        // Zero rate at the top of the seconds range.
        plan.push_back(packet_row(DIR_RX, 16'hFFFF, 32'hFFFF_FFFF, 20'd0, PREDICTED, 1'b0, 32'd0));
        plan.push_back(packet_row(DIR_RX, 16'd1, 32'hFFFF_FFFF, 20'd5, PREDICTED, 1'b0, 32'd0));
        plan.push_back(packet_row(DIR_TX, 16'd1, 32'd0, 20'd0, PREDICTED, 1'b0, 32'd0));

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CONFIG)
                write_reg(plan[i].idx, plan[i].data);
            else
                send_item(plan[i]);
        end

        // Random phases, each with its own register settings and a running time base.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            write_reg(REG_TX_ENABLE, (phase == 2) ? 32'd0 : 32'd1);
            write_reg(REG_RX_ENABLE, (phase == 5) ? 32'd0 : 32'd1);
            write_reg(REG_TX_RATE, (phase == 3) ? 32'hFFFF_FFFF :
                                   (phase == 6) ? 32'd0 : 32'($urandom_range(16, 2048)));
            write_reg(REG_RX_RATE, (phase == 6) ? 32'hFFFF_FFFF :
                                   (phase == 3) ? 32'd0 : 32'($urandom_range(16, 2048)));
            no_idle = (phase == 7);
            if (phase == 1 || phase == 6)
                pop_hold_request = 1'b1;
            clk_sec = (phase == 3) ? 32'hFFFF_FFF0 : 32'($urandom_range(1, 100000));
            clk_usec = $urandom_range(0, 999999);

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (phase == 4 && k == PHASE_ITEMS / 2)
                    wait_drained();

                roll = $urandom_range(0, 99);
                r = packet_row(1'($urandom_range(0, 1)), 16'd0, 32'd0, 20'd0,
                               PREDICTED, 1'b0, 32'd0);
                if (roll < 10)
                begin
                    // Noise: any length at any time, now and then an out-of-range microsecond.
                    r.len = 16'($urandom_range(0, 65535));
                    r.sec = $urandom();
                    r.usec = ($urandom_range(0, 19) == 0) ? 20'($urandom_range(0, 20'hFFFFF)) :
                                                            20'($urandom_range(0, 999999));
                end
                else
                begin
                    // Well-formed traffic: time moves forward by a short step, sometimes a long one.
                    usec_sum = clk_usec + (($urandom_range(0, 19) == 0) ?
                                           $urandom_range(0, 2500000) : $urandom_range(0, 3000));
                    clk_sec = clk_sec + usec_sum / 1000000;
                    clk_usec = usec_sum % 1000000;
                    roll = $urandom_range(0, 49);
                    r.len = (roll == 0) ? 16'd0 :
                            (roll == 1) ? 16'hFFFF : 16'($urandom_range(1, 1500));
                    r.sec = clk_sec;
                    r.usec = 20'(clk_usec);
                end
                send_item(r);
            end
        end

        // Drain, then keep watching the outputs for any stray item.
        push <= 1'b0;
        guard = 0;
        while (decision_q.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (decision_q.size() != 0)
            $display("%0t: %0d decisions never came out", $time, decision_q.size());

        if (mismatches == 0 && decision_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
